/* src/sbmfd_pkg.sv */
// Shared types and constants for the serial basic-mode frame decoder.
// Used by serial_basic_mode_frame_decoder_top; depends on nothing.
`timescale 1ns / 1ps
`default_nettype none

package sbmfd_pkg;

  // Sequencer states
  typedef enum logic [0:0] {
    ST_RUN   = 1'b0,
    ST_DRAIN = 1'b1
  } state_t;

  // Register indexes (byte address = 4 * index)
  localparam logic [2:0] REG_START     = 3'd0;
  localparam logic [2:0] REG_STOP      = 3'd1;
  localparam logic [2:0] REG_HANDSHAKE = 3'd2;
  localparam logic [2:0] REG_ESCAPE    = 3'd3;
  localparam logic [2:0] REG_CAPACITY  = 3'd4;

  // Register reset values
  localparam logic [7:0] RST_START     = 8'hA0;
  localparam logic [7:0] RST_STOP      = 8'hA5;
  localparam logic [7:0] RST_HANDSHAKE = 8'hA6;
  localparam logic [7:0] RST_ESCAPE    = 8'hAA;
  localparam logic [5:0] RST_CAPACITY  = 6'd32;

  // Escaped substitutes
  localparam logic [7:0] ESC_START     = 8'hB0;
  localparam logic [7:0] ESC_STOP      = 8'hB5;
  localparam logic [7:0] ESC_HANDSHAKE = 8'hB6;
  localparam logic [7:0] ESC_ESCAPE    = 8'hBA;
  localparam logic [7:0] ESC_LITERAL   = 8'h3B;
  localparam logic [7:0] LITERAL_VALUE = 8'h1B;

  // Result status codes
  localparam logic STATUS_OK       = 1'b0;
  localparam logic STATUS_OVERFLOW = 1'b1;

endpackage

`default_nettype wire

/* src/serial_basic_mode_frame_decoder_top.sv */
// Serial basic-mode frame decoder: deframes, unescapes and buffers one frame.
// Depends on sbmfd_pkg (state type, register indexes, escape constants).
// An empty-frame or overflow result sits in the output register the cycle
// after its byte. The first byte of a stored frame follows the stop byte via
// the drain state and the frame memory's registered read port, and the frame
// streams one byte a cycle while the output is free; input is held off during
// read-out. Throughput: one byte per cycle outside read-out while the output
// is free. Reset (rst_n, synchronous) clears control state and restores
// register defaults; memory is not cleared.
`timescale 1ns / 1ps
`default_nettype none

module serial_basic_mode_frame_decoder_top #(
  parameter int MAX_FRAME = 32
) (
  input  wire logic        clk,
  input  wire logic        rst_n,
  // Input stream
  input  wire logic        in_tvalid,
  output logic             in_tready,
  input  wire logic [7:0]  in_tdata,      // [7:0] rx_byte
  // Result stream
  output logic             out_tvalid,
  input  wire logic        out_tready,
  output logic [15:0]      out_tdata,     // [7:0] data_byte, [13:8] frame_size
  output logic [1:0]       out_tuser,     // [0] status, [1] has_data
  output logic             out_tlast,     // last
  // Configuration port
  input  wire logic        cfg_psel,
  input  wire logic        cfg_penable,
  input  wire logic        cfg_pwrite,
  input  wire logic [4:0]  cfg_paddr,
  input  wire logic [31:0] cfg_pwdata,
  output logic [31:0]      cfg_prdata,
  output logic             cfg_pready
);

  localparam int CntW  = $clog2(MAX_FRAME + 1);
  localparam int AddrW = (MAX_FRAME > 1) ? $clog2(MAX_FRAME) : 1;
  localparam int CmpW  = (CntW > 6) ? CntW : 6;

  // Configuration registers
  logic [7:0] start_code_r;
  logic [7:0] stop_code_r;
  logic [7:0] handshake_code_r;
  logic [7:0] escape_code_r;
  logic [5:0] frame_capacity_r;

  // Control state
  sbmfd_pkg::state_t state_r, state_nxt;
  logic              inside_r, inside_nxt;
  logic              esc_r, esc_nxt;
  logic [CntW-1:0]   cnt_r, cnt_nxt;
  logic [CntW-1:0]   len_r, len_nxt;
  logic [CntW-1:0]   rd_idx_r, rd_idx_nxt;

  // Output register
  logic              out_valid_r, out_valid_nxt;
  logic [7:0]        out_data_r, out_data_nxt;
  logic              out_status_r, out_status_nxt;
  logic [5:0]        out_len_r, out_len_nxt;
  logic              out_has_r, out_has_nxt;
  logic              out_last_r, out_last_nxt;

  // Frame memory
  logic [7:0]        mem [MAX_FRAME];
  logic [7:0]        mem_q;
  logic              mem_we;
  logic [7:0]        mem_wdata;

  logic              cfg_wr;
  logic              in_xfer;
  logic              out_free;
  logic [7:0]        c;
  logic              esc_ok;
  logic [7:0]        esc_val;
  logic              do_store;
  logic [7:0]        store_val;
  logic              cap_full;
  logic [CmpW-1:0]   cnt_w;
  logic [CmpW-1:0]   len_w;
  logic              drain_last;

  // Configuration writes and reads
  assign cfg_pready = 1'b1;
  assign cfg_wr     = cfg_psel & cfg_penable & cfg_pwrite & cfg_pready;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      start_code_r     <= sbmfd_pkg::RST_START;
      stop_code_r      <= sbmfd_pkg::RST_STOP;
      handshake_code_r <= sbmfd_pkg::RST_HANDSHAKE;
      escape_code_r    <= sbmfd_pkg::RST_ESCAPE;
      frame_capacity_r <= sbmfd_pkg::RST_CAPACITY;
    end else if (cfg_wr) begin
      case (cfg_paddr[4:2])
        sbmfd_pkg::REG_START:     start_code_r     <= cfg_pwdata[7:0];
        sbmfd_pkg::REG_STOP:      stop_code_r      <= cfg_pwdata[7:0];
        sbmfd_pkg::REG_HANDSHAKE: handshake_code_r <= cfg_pwdata[7:0];
        sbmfd_pkg::REG_ESCAPE:    escape_code_r    <= cfg_pwdata[7:0];
        sbmfd_pkg::REG_CAPACITY:  frame_capacity_r <= cfg_pwdata[5:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    case (cfg_paddr[4:2])
      sbmfd_pkg::REG_START:     cfg_prdata = {24'd0, start_code_r};
      sbmfd_pkg::REG_STOP:      cfg_prdata = {24'd0, stop_code_r};
      sbmfd_pkg::REG_HANDSHAKE: cfg_prdata = {24'd0, handshake_code_r};
      sbmfd_pkg::REG_ESCAPE:    cfg_prdata = {24'd0, escape_code_r};
      sbmfd_pkg::REG_CAPACITY:  cfg_prdata = {26'd0, frame_capacity_r};
      default:                  cfg_prdata = 32'd0;
    endcase
  end

  // Handshake
  assign out_free  = !out_valid_r || out_tready;
  assign in_tready = (state_r == sbmfd_pkg::ST_RUN) && out_free;
  assign in_xfer   = in_tvalid && in_tready;
  assign c         = in_tdata;

  // Map the byte after an escape back to its code
  always_comb begin
    esc_ok  = 1'b1;
    esc_val = 8'd0;
    case (c)
      sbmfd_pkg::ESC_START:     esc_val = start_code_r;
      sbmfd_pkg::ESC_STOP:      esc_val = stop_code_r;
      sbmfd_pkg::ESC_HANDSHAKE: esc_val = handshake_code_r;
      sbmfd_pkg::ESC_ESCAPE:    esc_val = escape_code_r;
      sbmfd_pkg::ESC_LITERAL:   esc_val = sbmfd_pkg::LITERAL_VALUE;
      default:                  esc_ok  = 1'b0;
    endcase
  end

  // Capacity check, saturated at MAX_FRAME
  assign cnt_w    = CmpW'(cnt_r);
  assign cap_full = (cnt_w >= CmpW'(frame_capacity_r)) ||
                    (cnt_w >= CmpW'(MAX_FRAME));
  assign len_w      = CmpW'(len_r);
  assign drain_last = (rd_idx_r + 1'b1) == len_r;

  // Next state
  always_comb begin
    state_nxt = state_r;
    case (state_r)
      sbmfd_pkg::ST_RUN: begin
        if (in_xfer && c != start_code_r && inside_r && !esc_r &&
            c != escape_code_r && c == stop_code_r && cnt_r != '0) begin
          state_nxt = sbmfd_pkg::ST_DRAIN;
        end
      end
      sbmfd_pkg::ST_DRAIN: begin
        if (out_free && drain_last) begin
          state_nxt = sbmfd_pkg::ST_RUN;
        end
      end
      default: state_nxt = sbmfd_pkg::ST_RUN;
    endcase
  end

  // Datapath and result selection
  always_comb begin
    inside_nxt     = inside_r;
    esc_nxt        = esc_r;
    cnt_nxt        = cnt_r;
    len_nxt        = len_r;
    rd_idx_nxt     = rd_idx_r;
    do_store       = 1'b0;
    store_val      = c;
    out_valid_nxt  = out_valid_r && !out_tready;
    out_data_nxt   = out_data_r;
    out_status_nxt = out_status_r;
    out_len_nxt    = out_len_r;
    out_has_nxt    = out_has_r;
    out_last_nxt   = out_last_r;

    case (state_r)
      sbmfd_pkg::ST_RUN: begin
        if (in_xfer) begin
          if (c == start_code_r) begin
            // Restart the frame
            inside_nxt = 1'b1;
            esc_nxt    = 1'b0;
            cnt_nxt    = '0;
          end else if (inside_r) begin
            if (esc_r) begin
              esc_nxt = 1'b0;
              if (esc_ok) begin
                do_store  = 1'b1;
                store_val = esc_val;
              end else begin
                // Drop the frame silently
                inside_nxt = 1'b0;
                cnt_nxt    = '0;
              end
            end else if (c == escape_code_r) begin
              esc_nxt = 1'b1;
            end else if (c == stop_code_r) begin
              inside_nxt = 1'b0;
              cnt_nxt    = '0;
              len_nxt    = cnt_r;
              rd_idx_nxt = '0;
              if (cnt_r == '0) begin
                // Emit the empty-frame result
                out_valid_nxt  = 1'b1;
                out_data_nxt   = 8'd0;
                out_status_nxt = sbmfd_pkg::STATUS_OK;
                out_len_nxt    = 6'd0;
                out_has_nxt    = 1'b0;
                out_last_nxt   = 1'b1;
              end
            end else if (c != handshake_code_r) begin
              do_store = 1'b1;
            end
          end
          if (do_store) begin
            if (cap_full) begin
              // Report overflow and drop the frame
              inside_nxt     = 1'b0;
              esc_nxt        = 1'b0;
              cnt_nxt        = '0;
              out_valid_nxt  = 1'b1;
              out_data_nxt   = 8'd0;
              out_status_nxt = sbmfd_pkg::STATUS_OVERFLOW;
              out_len_nxt    = 6'd0;
              out_has_nxt    = 1'b0;
              out_last_nxt   = 1'b1;
            end else begin
              cnt_nxt = cnt_r + 1'b1;
            end
          end
        end
      end
      sbmfd_pkg::ST_DRAIN: begin
        // Advance one stored byte per free output slot
        if (out_free) begin
          out_valid_nxt  = 1'b1;
          out_data_nxt   = mem_q;
          out_status_nxt = sbmfd_pkg::STATUS_OK;
          out_len_nxt    = len_w[5:0];
          out_has_nxt    = 1'b1;
          out_last_nxt   = drain_last;
          rd_idx_nxt     = drain_last ? '0 : rd_idx_r + 1'b1;
        end
      end
      default: ;
    endcase
  end

  assign mem_we    = do_store && !cap_full;
  assign mem_wdata = store_val;

  // Frame memory: one write port, one registered read port
  always_ff @(posedge clk) begin
    if (mem_we) begin
      mem[cnt_r[AddrW-1:0]] <= mem_wdata;
    end
  end

  always_ff @(posedge clk) begin
    mem_q <= mem[rd_idx_nxt[AddrW-1:0]];
  end

  // Control registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= sbmfd_pkg::ST_RUN;
      inside_r    <= 1'b0;
      esc_r       <= 1'b0;
      cnt_r       <= '0;
      len_r       <= '0;
      rd_idx_r    <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      inside_r    <= inside_nxt;
      esc_r       <= esc_nxt;
      cnt_r       <= cnt_nxt;
      len_r       <= len_nxt;
      rd_idx_r    <= rd_idx_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  // Output payload
  always_ff @(posedge clk) begin
    out_data_r   <= out_data_nxt;
    out_status_r <= out_status_nxt;
    out_len_r    <= out_len_nxt;
    out_has_r    <= out_has_nxt;
    out_last_r   <= out_last_nxt;
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = {2'b00, out_len_r, out_data_r};
  assign out_tuser  = {out_has_r, out_status_r};
  assign out_tlast  = out_last_r;

endmodule

`default_nettype wire
